// ----- rtl/correlating_predictor_with_btb_defines.svh -----
// Assertion macros used by the predictor top level
`ifndef CORRELATING_PREDICTOR_WITH_BTB_DEFINES_SVH
`define CORRELATING_PREDICTOR_WITH_BTB_DEFINES_SVH

// checked outside reset only
`define CPB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CPB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/cpb_pkg.sv -----
// Shared constants, types and helpers of the correlating predictor
package cpb_pkg;

    localparam int unsigned BTB_ENTRIES_DEF   = 64;
    localparam int unsigned HISTORY_BITS_DEF  = 2;
    localparam int unsigned PC_INDEX_BITS_DEF = 8;

    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned CFG_W     = 3;
    localparam logic [CFG_W-1:0] CFG_BTB_BITS_RST = 3'd6;

    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 168;
    localparam int unsigned RES_W     = 164;

    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;
    localparam logic [0:0]  REG_BTB_INDEX_BITS = 1'b0;

    typedef enum logic [1:0] {
        BTB_EMPTY    = 2'd0,
        BTB_CONFLICT = 2'd1,
        BTB_HIT      = 2'd2
    } t_btb_status;

    // first field in the highest bits
    typedef struct packed {
        logic [31:0] miss_count;
        logic [31:0] hit_count;
        logic [31:0] correct_count;
        logic [31:0] branch_count;
        logic [31:0] btb_stored_target;
        logic [1:0]  btb_status;
        logic        prediction_correct;
        logic        predicted_taken;
    } t_result;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

// ----- rtl/cpb_btb_index.sv -----
// Target buffer index: branch address reduced modulo the entries in use
module cpb_btb_index #(
    parameter int unsigned BTB_ENTRIES = cpb_pkg::BTB_ENTRIES_DEF,
    localparam int unsigned BI_W = (BTB_ENTRIES > 1) ? $clog2(BTB_ENTRIES) : 1
) (
    input  logic [cpb_pkg::ADDR_W-1:0] i_pc,
    input  logic [cpb_pkg::CFG_W-1:0]  i_index_bits,
    output logic [BI_W-1:0]            o_index
);

    localparam bit IS_POW2 = ((BTB_ENTRIES & (BTB_ENTRIES - 1)) == 0);
    localparam int unsigned SUM_W = BI_W + 2;

    logic [8:0]      w_span;
    logic            w_full;
    logic [BI_W-1:0] w_mask;
    logic [BI_W-1:0] w_mod;

    assign w_span = 9'd1 << i_index_bits;
    assign w_full = (32'(w_span) >= 32'(BTB_ENTRIES));
    assign w_mask = BI_W'(w_span - 9'd1);

    if (IS_POW2) begin : g_pow2
        assign w_mod = i_pc[BI_W-1:0] & BI_W'(BTB_ENTRIES - 1);
    end else begin : g_fold
        // byte residues: (x << 8k) mod BTB_ENTRIES
        logic [BI_W-1:0]  w_res [4][256];
        logic [SUM_W-1:0] w_sum;
        logic [SUM_W-1:0] w_r1;
        logic [SUM_W-1:0] w_r2;

        for (genvar gk = 0; gk < 4; gk++) begin : g_byte
            for (genvar gx = 0; gx < 256; gx++) begin : g_ent
                localparam longint FOLD = (longint'(gx) << (8 * gk)) % BTB_ENTRIES;
                assign w_res[gk][gx] = BI_W'(FOLD);
            end
        end

        assign w_sum = SUM_W'(w_res[0][i_pc[7:0]])   + SUM_W'(w_res[1][i_pc[15:8]])
                     + SUM_W'(w_res[2][i_pc[23:16]]) + SUM_W'(w_res[3][i_pc[31:24]]);
        assign w_r1  = (w_sum >= SUM_W'(2 * BTB_ENTRIES)) ? w_sum - SUM_W'(2 * BTB_ENTRIES)
                                                          : w_sum;
        assign w_r2  = (w_r1 >= SUM_W'(BTB_ENTRIES)) ? w_r1 - SUM_W'(BTB_ENTRIES) : w_r1;
        assign w_mod = w_r2[BI_W-1:0];
    end

    assign o_index = w_full ? w_mod : (i_pc[BI_W-1:0] & w_mask);

endmodule

// ----- rtl/cpb_fwd_ram.sv -----
// Single-write, registered-read memory with same-edge write forwarding
module cpb_fwd_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;
    logic [WIDTH-1:0] r_fwd_data;
    logic             r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd       <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // read racing a write to the same entry sees the old word: take the new one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd;

endmodule

// ----- rtl/correlating_predictor_with_btb.sv -----
// Path: an accepted transaction passes through stage 1 and then the result register to m_tdata.
// Throughput: one branch per cycle while m_tready does not hold the result register, set by
// the counter and target memories (one registered read and one write each per cycle, with write forwarding).
// Reset: synchronous, active low. A clearing pass over
// max(2^(PC_INDEX_BITS+HISTORY_BITS), BTB_ENTRIES) addresses (1024 by default)
// follows reset with s_tready low; register writes are taken throughout.
module correlating_predictor_with_btb #(
    parameter int unsigned BTB_ENTRIES   = cpb_pkg::BTB_ENTRIES_DEF,
    parameter int unsigned HISTORY_BITS  = cpb_pkg::HISTORY_BITS_DEF,
    parameter int unsigned PC_INDEX_BITS = cpb_pkg::PC_INDEX_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // branch_pc[31:0], branch_target[63:32], taken[64], zero [71:65]
    input  logic [cpb_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // predicted_taken[0], prediction_correct[1], btb_status[3:2],
    // btb_stored_target[35:4], branch_count[67:36], correct_count[99:68],
    // hit_count[131:100], miss_count[163:132], zero [167:164]
    output logic [cpb_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cpb_pkg::APB_AW-1:0]      paddr,
    input  logic [cpb_pkg::APB_DW-1:0]      pwdata,
    output logic [cpb_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    localparam int unsigned AW        = cpb_pkg::ADDR_W;
    localparam int unsigned BI_W      = (BTB_ENTRIES > 1) ? $clog2(BTB_ENTRIES) : 1;
    localparam int unsigned HW        = (HISTORY_BITS > 0) ? HISTORY_BITS : 1;
    localparam int unsigned DI_W      = PC_INDEX_BITS + HISTORY_BITS;
    localparam int unsigned DIR_DEPTH = 1 << DI_W;
    localparam int unsigned CLR_DEPTH = (DIR_DEPTH > BTB_ENTRIES) ? DIR_DEPTH : BTB_ENTRIES;
    localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);
    localparam int unsigned ENT_W     = 2 * AW + 1;

    // configuration
    logic [cpb_pkg::CFG_W-1:0] r_cfg;
    logic                      w_cfg_sel;

    assign pready    = 1'b1;
    assign w_cfg_sel = (paddr[cpb_pkg::APB_AW-1:2] == cpb_pkg::REG_BTB_INDEX_BITS);
    assign prdata    = w_cfg_sel ? cpb_pkg::APB_DW'(r_cfg) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= cpb_pkg::CFG_BTB_BITS_RST;
        end else if (psel && penable && pwrite && pready && w_cfg_sel) begin
            r_cfg <= pwdata[cpb_pkg::CFG_W-1:0];
        end
    end

    // clearing pass
    logic             r_clr_busy;
    logic [CLR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + CLR_W'(1);
            if (r_clr_addr == CLR_W'(CLR_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // handshake
    logic r_s1_valid;
    logic r_o_valid;
    logic w_s1_adv;
    logic w_acc;

    assign w_s1_adv = r_s1_valid && (!r_o_valid || m_tready);
    assign s_tready = !r_clr_busy && (!r_s1_valid || w_s1_adv);
    assign w_acc    = s_tvalid && s_tready;

    // input decode and indices
    logic [AW-1:0]   w_pc;
    logic [AW-1:0]   w_tgt;
    logic            w_tk;
    logic [HW-1:0]   r_hist;
    logic [DI_W-1:0] w_di;
    logic [BI_W-1:0] w_bi;

    assign w_pc  = s_tdata[AW-1:0];
    assign w_tgt = s_tdata[2*AW-1:AW];
    assign w_tk  = s_tdata[2*AW];
    assign w_di  = DI_W'({r_hist, w_pc[PC_INDEX_BITS-1:0]});

    cpb_btb_index #(
        .BTB_ENTRIES (BTB_ENTRIES)
    ) u_index (
        .i_pc         (w_pc),
        .i_index_bits (r_cfg),
        .o_index      (w_bi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (w_acc) begin
            r_hist <= HW'({r_hist, w_tk});
        end
    end

    // stage 1
    logic [AW-1:0]   r_s1_pc;
    logic [AW-1:0]   r_s1_tgt;
    logic            r_s1_tk;
    logic [DI_W-1:0] r_s1_di;
    logic [BI_W-1:0] r_s1_bi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_pc  <= w_pc;
            r_s1_tgt <= w_tgt;
            r_s1_tk  <= w_tk;
            r_s1_di  <= w_di;
            r_s1_bi  <= w_bi;
        end
    end

    // memories
    logic [1:0]       w_ctr;
    logic [1:0]       n_ctr;
    logic             w_dir_we;
    logic [DI_W-1:0]  w_dir_wa;
    logic [1:0]       w_dir_wd;
    logic [ENT_W-1:0] w_ent;
    logic             w_btb_we;
    logic [BI_W-1:0]  w_btb_wa;
    logic [ENT_W-1:0] w_btb_wd;

    assign w_dir_we = r_clr_busy ? ({1'b0, r_clr_addr} < (CLR_W + 1)'(DIR_DEPTH)) : w_s1_adv;
    assign w_dir_wa = r_clr_busy ? r_clr_addr[DI_W-1:0] : r_s1_di;
    assign w_dir_wd = r_clr_busy ? 2'd0 : n_ctr;

    assign w_btb_we = r_clr_busy ? ({1'b0, r_clr_addr} < (CLR_W + 1)'(BTB_ENTRIES)) : w_s1_adv;
    assign w_btb_wa = r_clr_busy ? r_clr_addr[BI_W-1:0] : r_s1_bi;
    assign w_btb_wd = r_clr_busy ? '0 : {1'b1, r_s1_pc, r_s1_tgt};

    cpb_fwd_ram #(
        .WIDTH (2),
        .DEPTH (DIR_DEPTH)
    ) u_dir_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_acc),
        .i_rd_addr (w_di),
        .i_wr_en   (w_dir_we),
        .i_wr_addr (w_dir_wa),
        .i_wr_data (w_dir_wd),
        .o_rd_data (w_ctr)
    );

    cpb_fwd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (BTB_ENTRIES)
    ) u_btb_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_acc),
        .i_rd_addr (w_bi),
        .i_wr_en   (w_btb_we),
        .i_wr_addr (w_btb_wa),
        .i_wr_data (w_btb_wd),
        .o_rd_data (w_ent)
    );

    // prediction, training and lookup
    logic                 w_pred;
    logic                 w_ok;
    cpb_pkg::t_btb_status w_status;
    logic [AW-1:0]        w_stored;

    assign w_pred = w_ctr[1];
    assign w_ok   = (w_pred == r_s1_tk);

    always_comb begin
        if (r_s1_tk) begin
            n_ctr = (w_ctr == 2'd3) ? w_ctr : w_ctr + 2'd1;
        end else begin
            n_ctr = (w_ctr == 2'd0) ? w_ctr : w_ctr - 2'd1;
        end
    end

    always_comb begin
        w_stored = '0;
        if (!w_ent[ENT_W-1]) begin
            w_status = cpb_pkg::BTB_EMPTY;
        end else if (w_ent[2*AW-1:AW] != r_s1_pc) begin
            w_status = cpb_pkg::BTB_CONFLICT;
        end else begin
            w_status = cpb_pkg::BTB_HIT;
            w_stored = w_ent[AW-1:0];
        end
    end

    // running totals
    logic [31:0] r_tot_branch;
    logic [31:0] r_tot_correct;
    logic [31:0] r_tot_hit;
    logic [31:0] r_tot_miss;
    logic [31:0] n_tot_branch;
    logic [31:0] n_tot_correct;
    logic [31:0] n_tot_hit;
    logic [31:0] n_tot_miss;

    assign n_tot_branch  = cpb_pkg::sat_inc(r_tot_branch);
    assign n_tot_correct = w_ok ? cpb_pkg::sat_inc(r_tot_correct) : r_tot_correct;
    assign n_tot_hit     = (w_status == cpb_pkg::BTB_HIT) ? cpb_pkg::sat_inc(r_tot_hit)
                                                          : r_tot_hit;
    assign n_tot_miss    = (w_status != cpb_pkg::BTB_HIT) ? cpb_pkg::sat_inc(r_tot_miss)
                                                          : r_tot_miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot_branch  <= '0;
            r_tot_correct <= '0;
            r_tot_hit     <= '0;
            r_tot_miss    <= '0;
        end else if (w_s1_adv) begin
            r_tot_branch  <= n_tot_branch;
            r_tot_correct <= n_tot_correct;
            r_tot_hit     <= n_tot_hit;
            r_tot_miss    <= n_tot_miss;
        end
    end

    // result register
    cpb_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_res.predicted_taken    <= w_pred;
            r_res.prediction_correct <= w_ok;
            r_res.btb_status         <= w_status;
            r_res.btb_stored_target  <= w_stored;
            r_res.branch_count       <= n_tot_branch;
            r_res.correct_count      <= n_tot_correct;
            r_res.hit_count          <= n_tot_hit;
            r_res.miss_count         <= n_tot_miss;
        end
    end

    assign m_tvalid = r_o_valid;
    assign m_tdata  = cpb_pkg::M_TDATA_W'(r_res);

`include "correlating_predictor_with_btb_defines.svh"

    `CPB_ASSERT(a_clr_blocks_input, r_clr_busy |-> !s_tready, "input taken during clearing pass")
    `CPB_ASSERT(a_adv_fills_output, w_s1_adv |=> r_o_valid, "stage 1 result not registered")
    `CPB_ASSERT(a_correct_le_branch, r_tot_correct <= r_tot_branch, "correct total above branch total")
    `CPB_ASSERT(a_hit_le_branch, r_tot_hit <= r_tot_branch, "hit total above branch total")
    `CPB_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (r_clr_busy && !r_s1_valid && !r_o_valid), "reset did not clear control state")

endmodule

// ----- verif/correlating_predictor_with_btb_tb.sv -----
// Self-checking testbench for the correlating branch predictor with target buffer
module correlating_predictor_with_btb_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PCI_W  = cpb_pkg::PC_INDEX_BITS_DEF;
    localparam int unsigned HIST_W = cpb_pkg::HISTORY_BITS_DEF;
    localparam int unsigned CTR_N  = 1 << (PCI_W + HIST_W);
    localparam int unsigned POOL_N = 16;
    localparam logic [cpb_pkg::APB_AW-1:0] ADDR_BTB_BITS =
        {cpb_pkg::REG_BTB_INDEX_BITS, 2'b00};
    localparam logic [cpb_pkg::APB_AW-1:0] ADDR_UNMAPPED = 3'd4;
    localparam int unsigned STALL_CYCLES = 80;

    typedef struct packed {
        logic        taken;
        logic [31:0] target;
        logic [31:0] pc;
    } t_branch;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // branch_pc[31:0], branch_target[63:32], taken[64], zero [71:65]
    logic [cpb_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // predicted_taken[0], prediction_correct[1], btb_status[3:2],
    // btb_stored_target[35:4], branch_count[67:36], correct_count[99:68],
    // hit_count[131:100], miss_count[163:132], zero [167:164]
    logic [cpb_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [cpb_pkg::APB_AW-1:0]    paddr = '0;
    logic [cpb_pkg::APB_DW-1:0]    pwdata = '0;
    logic [cpb_pkg::APB_DW-1:0]    prdata;
    logic                          pready;

    correlating_predictor_with_btb dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [cpb_pkg::CFG_W-1:0] btb_bits = cpb_pkg::CFG_BTB_BITS_RST;
    bit                tgt_valid [cpb_pkg::BTB_ENTRIES_DEF];
    logic [31:0]       tgt_tag   [cpb_pkg::BTB_ENTRIES_DEF];
    logic [31:0]       tgt_addr  [cpb_pkg::BTB_ENTRIES_DEF];
    bit [1:0]          dir_ctr   [CTR_N];
    bit [HIST_W-1:0]   recent_outcomes = '0;
    logic [31:0]       n_branches = '0;
    logic [31:0]       n_correct = '0;
    logic [31:0]       n_hits = '0;
    logic [31:0]       n_misses = '0;

    t_branch pending_branches[$];
    cpb_pkg::t_result expected_results[$];
    int unsigned mismatches = 0;
    bit s_took = 1'b0;
    int unsigned send_idle_pct = 38;
    int unsigned recv_idle_pct = 79;
    int unsigned stall_reqs = 0;
    int unsigned stall_done = 0;
    int unsigned stall_left = 0;

    logic [31:0] pool_pc   [POOL_N];
    logic [31:0] pool_tgt  [POOL_N];
    int unsigned pool_seen [POOL_N];
    int unsigned pool_trip [POOL_N];

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic cpb_pkg::t_result predict_branch(input t_branch b);
        cpb_pkg::t_result r;
        logic [PCI_W+HIST_W-1:0] ci;
        bit [1:0] ctr;
        int unsigned n_ent;
        int unsigned bi;
        r = '0;
        ci = {recent_outcomes, b.pc[PCI_W-1:0]};
        ctr = dir_ctr[ci];
        r.predicted_taken = ctr[1];
        r.prediction_correct = (ctr[1] == b.taken);
        if (b.taken && ctr != 2'd3) ctr = ctr + 2'd1;
        else if (!b.taken && ctr != 2'd0) ctr = ctr - 2'd1;
        dir_ctr[ci] = ctr;
        recent_outcomes = HIST_W'({recent_outcomes, b.taken});

        n_ent = 1 << btb_bits;
        if (n_ent > cpb_pkg::BTB_ENTRIES_DEF) n_ent = cpb_pkg::BTB_ENTRIES_DEF;
        bi = b.pc % n_ent;
        if (!tgt_valid[bi]) begin
            r.btb_status = cpb_pkg::BTB_EMPTY;
        end else if (tgt_tag[bi] != b.pc) begin
            r.btb_status = cpb_pkg::BTB_CONFLICT;
        end else begin
            r.btb_status = cpb_pkg::BTB_HIT;
            r.btb_stored_target = tgt_addr[bi];
        end
        tgt_valid[bi] = 1'b1;
        tgt_tag[bi] = b.pc;
        tgt_addr[bi] = b.target;

        n_branches = bump(n_branches);
        if (r.prediction_correct) n_correct = bump(n_correct);
        if (r.btb_status == cpb_pkg::BTB_HIT) n_hits = bump(n_hits);
        else n_misses = bump(n_misses);
        r.branch_count = n_branches;
        r.correct_count = n_correct;
        r.hit_count = n_hits;
        r.miss_count = n_misses;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h got %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // monitor: accepted transactions on both streams and the config port
    always @(posedge i_clk) begin
        cpb_pkg::t_result got;
        cpb_pkg::t_result want;
        if (!i_rst_n) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_branch(t_branch'(s_tdata[64:0])));
            if (psel && penable && pready && paddr == ADDR_BTB_BITS) begin
                if (pwrite) btb_bits = pwdata[cpb_pkg::CFG_W-1:0];
                else check_field("prdata", {29'd0, btb_bits}, prdata);
            end
            if (m_tvalid && m_tready) begin
                got = cpb_pkg::t_result'(m_tdata[cpb_pkg::RES_W-1:0]);
                if (expected_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none got %h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("predicted_taken", want.predicted_taken, got.predicted_taken);
                    check_field("prediction_correct", want.prediction_correct,
                                got.prediction_correct);
                    check_field("btb_status", want.btb_status, got.btb_status);
                    check_field("btb_stored_target", want.btb_stored_target,
                                got.btb_stored_target);
                    check_field("branch_count", want.branch_count, got.branch_count);
                    check_field("correct_count", want.correct_count, got.correct_count);
                    check_field("hit_count", want.hit_count, got.hit_count);
                    check_field("miss_count", want.miss_count, got.miss_count);
                end
            end
        end
    end

    // branch driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_took) void'(pending_branches.pop_front());
            if (s_tvalid && !s_took) begin
                // hold the offered transaction
            end else if (pending_branches.size() != 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= {7'd0, pending_branches[0]};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result sink with random back-pressure and long hold-offs on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (stall_done != stall_reqs) begin
            stall_done <= stall_done + 1;
            stall_left <= STALL_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send(input logic [31:0] pc, input logic [31:0] tgt, input logic tk);
        t_branch b;
        b.pc = pc;
        b.target = tgt;
        b.taken = tk;
        pending_branches.push_back(b);
    endtask

    task automatic wait_drained();
        while (pending_branches.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [cpb_pkg::APB_AW-1:0] addr,
                              input logic [cpb_pkg::APB_DW-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_btb_bits(input logic [cpb_pkg::CFG_W-1:0] v);
        apb_access(1'b1, ADDR_BTB_BITS, ($urandom & ~32'h7) | v);
        apb_access(1'b0, ADDR_BTB_BITS, '0);
    endtask

    task automatic refresh_pool();
        for (int unsigned k = 0; k < POOL_N; k++) begin
            if (k < POOL_N / 2) pool_pc[k] = $urandom;
            else pool_pc[k] = pool_pc[k - POOL_N / 2] ^ (32'h1 << $urandom_range(6, 31));
            pool_tgt[k] = $urandom;
            pool_seen[k] = 0;
            pool_trip[k] = $urandom_range(2, 6);
        end
    endtask

    // mostly recurring branches with loop-like outcomes, the rest noise
    task automatic push_random(input int unsigned n);
        int unsigned k;
        logic tk;
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 70) begin
                k = $urandom_range(0, POOL_N - 1);
                if ($urandom_range(0, 9) == 0) pool_tgt[k] = $urandom;
                tk = (pool_seen[k] % pool_trip[k]) != pool_trip[k] - 1;
                if ($urandom_range(0, 9) == 0) tk = ~tk;
                pool_seen[k]++;
                send(pool_pc[k], pool_tgt[k], tk);
            end else begin
                send($urandom, $urandom, $urandom_range(0, 1));
            end
        end
    endtask

    initial begin
        logic [cpb_pkg::CFG_W-1:0] sweep [9];
        sweep = '{3'd6, 3'd0, 3'd3, 3'd7, 3'd1, 3'd5, 3'd2, 3'd4, 3'd6};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: buffer empty, hit, conflict, field extremes, counter saturation
        apb_access(1'b0, ADDR_BTB_BITS, '0);
        send(32'h0000_0000, 32'h0000_0000, 1'b0);
        send(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        send(32'h0000_0000, 32'h1234_5678, 1'b1);
        send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send(32'h0000_0040, 32'hA5A5_A5A5, 1'b1);
        repeat (4) send(32'h0000_0080, 32'h8080_8080, 1'b1);
        repeat (3) send(32'h0000_0080, 32'h8080_8080, 1'b0);
        wait_drained();
        // unmapped register, then a single entry in use
        apb_access(1'b1, ADDR_UNMAPPED, 32'h0);
        send(32'h0000_0005, 32'h0000_0011, 1'b1);
        send(32'h0000_0006, 32'h0000_0022, 1'b0);
        wait_drained();
        set_btb_bits(3'd0);
        send(32'h0000_0100, 32'h0000_0001, 1'b1);
        send(32'h0000_0100, 32'h0000_0002, 1'b0);
        send(32'hFFFF_FFFF, 32'h0000_0003, 1'b1);
        wait_drained();
        // beyond range caps at the full buffer; old entries survive a resize
        set_btb_bits(3'd7);
        send(32'h0000_007F, 32'h0000_0004, 1'b1);
        send(32'hFFFF_FFFF, 32'h0000_0005, 1'b0);
        send(32'h0000_0100, 32'h0000_0006, 1'b1);
        wait_drained();

        for (int unsigned p = 0; p < 9; p++) begin
            set_btb_bits(sweep[p]);
            if (p < 3) begin
                send_idle_pct = 38;
                recv_idle_pct = 79;
            end else if (p < 6) begin
                send_idle_pct = 79;
                recv_idle_pct = 38;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            refresh_pool();
            if (p == 2 || p == 6) begin
                push_random(60);
                stall_reqs++;
                push_random(95);
            end else begin
                push_random(155);
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("correlating_predictor_with_btb test passed");
        end else begin
            $display("correlating_predictor_with_btb test failed");
        end
        $finish;
    end

    initial begin
        #400_000;
        $display("correlating_predictor_with_btb test failed");
        $finish;
    end

endmodule

// ----- correlating_predictor_with_btb.f -----
+incdir+rtl
rtl/cpb_pkg.sv
rtl/cpb_btb_index.sv
rtl/cpb_fwd_ram.sv
rtl/correlating_predictor_with_btb.sv
verif/correlating_predictor_with_btb_tb.sv
